### rtl/pse_pkg.sv
package pse_pkg;

  localparam int PositionBitsDefault = 32;
  localparam int MinLengthBits = 16;
  localparam logic [MinLengthBits-1:0] MinRunLengthReset = 16'd10;
  localparam int LetterBits = 32;
  localparam int FiveLetterBits = LetterBits + 3;
  localparam int EventQueueDepthLog2 = 2;
  localparam int ResultQueueDepthLog2 = 1;

  localparam logic [7:0] CharTab = 8'd9;
  localparam logic [7:0] CharLf = 8'd10;
  localparam logic [7:0] CharCr = 8'd13;
  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharTilde = 8'd126;
  localparam logic [7:0] CharUpperA = 8'd65;
  localparam logic [7:0] CharUpperZ = 8'd90;
  localparam logic [7:0] CharLowerA = 8'd97;
  localparam logic [7:0] CharLowerZ = 8'd122;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_word_t;

  typedef struct packed {
    logic [31:0] string_offset;
    logic [31:0] string_length;
    logic        final_string;
  } out_word_t;

  function automatic logic is_text(input logic [7:0] b);
    return (b >= CharSpace && b <= CharTilde) || b == CharTab || b == CharLf || b == CharCr;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == CharSpace || b == CharTab || b == CharLf || b == CharCr;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= CharUpperA && b <= CharUpperZ) || (b >= CharLowerA && b <= CharLowerZ);
  endfunction

endpackage

### rtl/printable_string_extractor_top.sv
// channel  | handshake          | payload
// item     | push / full        | data_byte, end_of_data
// result   | pop / empty        | string_offset, string_length, final_string
// config   | cfg_we             | cfg_data (min_run_length)
//
// one byte accepted per cycle unless full; results go through s1 to the result queue
// the front tracks the open run, a four-word event queue feeds the back end
// full rises only when the event queue fills, which happens when pop is held low
// reset is synchronous: positions clear to zero and min_run_length returns to 10
module printable_string_extractor_top #(
  parameter int POSITION_BITS = pse_pkg::PositionBitsDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  pse_pkg::in_word_t                item,
  output logic                             empty,
  input  logic                             pop,
  output pse_pkg::out_word_t               result,
  input  logic                             cfg_we,
  input  logic [pse_pkg::MinLengthBits-1:0] cfg_data
);

  import pse_pkg::*;

  localparam int EW = 3 * POSITION_BITS + LetterBits + 2;

  logic          accept;
  logic          ev_push;
  logic [EW-1:0] ev_in;
  logic [EW-1:0] ev_out;
  logic          ev_full;
  logic          ev_empty;
  logic          ev_pop;
  logic          res_push;
  logic          res_full;
  out_word_t     res_word;

  assign full   = ev_full;
  assign accept = push && !ev_full;

  pse_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .ev_push (ev_push),
    .ev_data (ev_in)
  );

  pse_fifo #(
    .WIDTH      (EW),
    .DEPTH_LOG2 (EventQueueDepthLog2)
  ) u_event_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_push),
    .push_data (ev_in),
    .full      (ev_full),
    .pop       (ev_pop),
    .pop_data  (ev_out),
    .empty     (ev_empty)
  );

  pse_back #(
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .ev_empty (ev_empty),
    .ev_data  (ev_out),
    .ev_pop   (ev_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_word (res_word)
  );

  pse_fifo #(
    .WIDTH      ($bits(out_word_t)),
    .DEPTH_LOG2 (ResultQueueDepthLog2)
  ) u_result_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_word),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (result),
    .empty     (empty)
  );

endmodule

### rtl/pse_fifo.sv
module pse_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH_LOG2 = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int Depth = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0]    slots [Depth];
  logic [DEPTH_LOG2-1:0] head;
  logic [DEPTH_LOG2-1:0] tail;
  logic [DEPTH_LOG2:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign full     = count == (DEPTH_LOG2+1)'(Depth);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= tail + 1'b1;
      end
      if (do_pop) begin
        head <= head + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= push_data;
    end
  end

endmodule

### rtl/pse_front.sv
module pse_front #(
  parameter int POSITION_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  pse_pkg::in_word_t      item,
  output logic                   ev_push,
  output logic [3*POSITION_BITS+pse_pkg::LetterBits+1:0] ev_data
);

  import pse_pkg::*;

  localparam int PW = POSITION_BITS;

  logic [PW-1:0]         byte_position;
  logic [PW-1:0]         run_start;
  logic [PW-1:0]         first_nonspace;
  logic [PW-1:0]         last_nonspace;
  logic                  seen_nonspace;
  logic [LetterBits-1:0] letter_count;

  logic                  text;
  logic                  blank;
  logic                  letter;
  logic                  fin;
  logic [PW-1:0]         pos_inc;
  logic [PW-1:0]         first_next;
  logic [PW-1:0]         last_next;
  logic                  seen_next;
  logic [LetterBits-1:0] letter_next;
  logic [PW-1:0]         run_len;

  assign text    = is_text(item.data_byte);
  assign blank   = is_blank(item.data_byte);
  assign letter  = is_letter(item.data_byte);
  assign fin     = item.end_of_data;
  assign pos_inc = byte_position + 1'b1;

  always_comb begin
    first_next  = (!blank && !seen_nonspace) ? byte_position : first_nonspace;
    last_next   = !blank ? byte_position : last_nonspace;
    seen_next   = seen_nonspace | !blank;
    letter_next = (letter && letter_count != '1) ? letter_count + 1'b1 : letter_count;
    run_len     = text ? pos_inc - run_start : byte_position - run_start;
  end

  // a run closes on any non-text byte or on the end marker
  assign ev_push = accept && (!text || fin);
  assign ev_data = text ? {run_len, first_next, last_next, letter_next, seen_next, fin}
                        : {run_len, first_nonspace, last_nonspace, letter_count,
                           seen_nonspace, fin};

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      run_start      <= '0;
      first_nonspace <= '0;
      last_nonspace  <= '0;
      seen_nonspace  <= 1'b0;
      letter_count   <= '0;
    end else if (accept) begin
      if (fin) begin
        byte_position  <= '0;
        run_start      <= '0;
        first_nonspace <= '0;
        last_nonspace  <= '0;
        seen_nonspace  <= 1'b0;
        letter_count   <= '0;
      end else if (text) begin
        byte_position  <= pos_inc;
        first_nonspace <= first_next;
        last_nonspace  <= last_next;
        seen_nonspace  <= seen_next;
        letter_count   <= letter_next;
      end else begin
        byte_position  <= pos_inc;
        run_start      <= pos_inc;
        first_nonspace <= '0;
        last_nonspace  <= '0;
        seen_nonspace  <= 1'b0;
        letter_count   <= '0;
      end
    end
  end

endmodule

### rtl/pse_back.sv
module pse_back #(
  parameter int POSITION_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [pse_pkg::MinLengthBits-1:0] cfg_data,
  input  logic                   ev_empty,
  input  logic [3*POSITION_BITS+pse_pkg::LetterBits+1:0] ev_data,
  output logic                   ev_pop,
  input  logic                   res_full,
  output logic                   res_push,
  output pse_pkg::out_word_t     res_word
);

  import pse_pkg::*;

  localparam int PW = POSITION_BITS;
  localparam int LW = (PW > MinLengthBits) ? PW : MinLengthBits;
  localparam int CW = (PW + 2 > FiveLetterBits + 1) ? PW + 2 : FiveLetterBits + 1;

  logic [MinLengthBits-1:0] min_run_length;

  logic [PW-1:0]         ev_run_len;
  logic [PW-1:0]         ev_first;
  logic [PW-1:0]         ev_last;
  logic [LetterBits-1:0] ev_letters;
  logic                  ev_seen;
  logic                  ev_fin;

  logic                      s1_valid;
  logic                      s1_ok;
  logic [FiveLetterBits-1:0] s1_five;
  logic [PW-1:0]             s1_tlen;
  logic [PW-1:0]             s1_first;
  logic                      s1_fin;
  logic                      advance;
  logic                      dense;

  assign {ev_run_len, ev_first, ev_last, ev_letters, ev_seen, ev_fin} = ev_data;

  assign advance = !s1_valid || !res_full;
  assign ev_pop  = advance && !ev_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_run_length <= MinRunLengthReset;
    end else if (cfg_we) begin
      min_run_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= !ev_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ok    <= ev_seen && (LW'(ev_run_len) >= LW'(min_run_length));
      s1_five  <= {3'b000, ev_letters} + {1'b0, ev_letters, 2'b00};
      s1_tlen  <= ev_last - ev_first + 1'b1;
      s1_first <= ev_first;
      s1_fin   <= ev_fin;
    end
  end

  // 5*letters stays below 2^35 and so fits s1_five; it is compared with 2*tlen at CW bits
  assign dense = CW'(s1_five) > CW'({s1_tlen, 1'b0});

  assign res_push                = s1_valid && !res_full && s1_ok && dense;
  assign res_word.string_offset = 32'(s1_first);
  assign res_word.string_length = 32'(s1_tlen);
  assign res_word.final_string  = s1_fin;

endmodule
